// File: rtl/core/qfp_pkg.sv
package qfp_pkg;

    localparam int QFP_MAX_FIELDS = 64;
    localparam int QFP_FIELD_W    = 6;
    localparam int QFP_FIFO_DEPTH = 4;
    localparam int QFP_HOLD_DEPTH = 4;   // entity bytes kept after the '&'
    localparam int QFP_RP_DEPTH   = 5;   // bytes waiting to be parsed again

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_C = 8'h43;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LEAD_C2 = 8'hC2;
    localparam logic [7:0] CH_LEAD_C3 = 8'hC3;
    localparam logic [7:0] LATIN_OFS  = 8'h40;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_EOF  = 2'd1,
        KIND_NULL = 2'd2,
        KIND_EOL  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CLS_PLAIN,
        CLS_QUOTE,
        CLS_COMMA,
        CLS_AMP
    } byte_cls_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        byte_cls_t  cls;
    } qfp_item_t;

    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             data;
        logic [QFP_FIELD_W-1:0] field;
    } qfp_result_t;

    function automatic byte_cls_t classify(input logic [7:0] c);
        byte_cls_t cls;
        cls = CLS_PLAIN;
        if (c == CH_QUOTE)
        begin
            cls = CLS_QUOTE;
        end
        else if (c == CH_COMMA)
        begin
            cls = CLS_COMMA;
        end
        else if (c == CH_AMP)
        begin
            cls = CLS_AMP;
        end
        return cls;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'b0;
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9)
        begin
            d = c - CH_DIGIT0;
            r = {1'b1, d[3:0]};
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            d = c - CH_UPPER_A + 8'd10;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

    // highest field index: one below the field limit, capped by the port width
    function automatic logic [QFP_FIELD_W-1:0] field_limit(input int max_fields);
        int lim;
        lim = max_fields - 1;
        if (lim > (2 ** QFP_FIELD_W) - 1)
        begin
            lim = (2 ** QFP_FIELD_W) - 1;
        end
        return QFP_FIELD_W'(lim);
    endfunction

endpackage

// File: rtl/core/qfp_front.sv
module qfp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tlast,
    output logic               head_valid,
    output qfp_pkg::qfp_item_t head,
    input  logic               pop
);

    localparam int DEPTH = qfp_pkg::QFP_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qfp_pkg::qfp_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               wr_en;
    logic               rd_en;
    qfp_pkg::qfp_item_t wr_item;

    assign s_tready   = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign wr_en      = s_tvalid && s_tready;
    assign rd_en      = pop && head_valid;

    // classify on the way in
    always_comb
    begin
        wr_item.data = s_tdata;
        wr_item.last = s_tlast;
        wr_item.cls  = qfp_pkg::classify(s_tdata);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: rtl/core/qfp_back.sv
module qfp_back #(
    parameter int MAX_FIELDS = qfp_pkg::QFP_MAX_FIELDS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  qfp_pkg::qfp_item_t   head,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output qfp_pkg::qfp_result_t res,
    output logic                 res_last
);

    localparam int HD = qfp_pkg::QFP_HOLD_DEPTH;
    localparam int RD = qfp_pkg::QFP_RP_DEPTH;
    localparam int FW = qfp_pkg::QFP_FIELD_W;
    localparam logic [FW-1:0] FIELD_LIMIT = qfp_pkg::field_limit(MAX_FIELDS);

    typedef enum logic [2:0] {
        MODE_OUTSIDE,
        MODE_QSEEN,
        MODE_SKIP,
        MODE_FIELD,
        MODE_ENTITY
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [FW-1:0]        field_reg, field_next;
    logic [7:0]           hold_reg [HD];
    logic [7:0]           rp_reg [RD];
    logic [7:0]           rp_next [RD];
    logic [2:0]           rp_len_reg, rp_len_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [7:0]           pend_byte_reg, pend_byte_next;
    logic                 le_pend_reg, le_pend_next;
    logic                 fin_pend_reg, fin_pend_next;
    logic                 stage_valid_reg, stage_valid_next;
    qfp_pkg::qfp_result_t stage_reg, stage_next;
    logic                 out_valid_reg;
    qfp_pkg::qfp_result_t out_reg;
    logic                 out_last_reg;

    logic                 step, fin_step, byte_step, from_rp, pop_want;
    logic [7:0]           b;
    qfp_pkg::byte_cls_t   b_cls;
    logic                 field_path, ent_ok, bump;
    logic                 hold_we;
    logic [1:0]           hold_idx;
    logic [2:0]           k, rest_len, rp_src;
    logic [4:0]           hex_hi, hex_lo;
    logic [7:0]           dec_val;
    logic                 r_valid;
    qfp_pkg::qfp_result_t r;
    logic                 done, push, push_last, can_push, go;
    qfp_pkg::qfp_result_t push_res;

    always_comb
    begin
        mode_next       = mode_reg;
        cnt_next        = cnt_reg;
        field_next      = field_reg;
        rp_len_next     = rp_len_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        le_pend_next    = le_pend_reg;
        for (int i = 0; i < RD; i++)
        begin
            rp_next[i] = rp_reg[i];
        end
        step       = 1'b0;
        fin_step   = 1'b0;
        byte_step  = 1'b0;
        from_rp    = 1'b0;
        pop_want   = 1'b0;
        b          = head.data;
        b_cls      = head.cls;
        field_path = 1'b0;
        ent_ok     = 1'b0;
        bump       = 1'b0;
        hold_we    = 1'b0;
        hold_idx   = 2'(cnt_reg - 3'd1);
        k          = cnt_reg - 3'd1;
        rest_len   = 3'd0;
        rp_src     = 3'd0;
        hex_hi     = qfp_pkg::hex_digit(hold_reg[2]);
        hex_lo     = qfp_pkg::hex_digit(hold_reg[3]);
        dec_val    = {hex_hi[3:0], hex_lo[3:0]};
        r_valid    = 1'b0;
        r.kind     = qfp_pkg::KIND_BYTE;
        r.data     = 8'h00;
        r.field    = field_reg;

        // pick the work source
        priority if (fin_pend_reg)
        begin
            fin_step = 1'b1;
        end
        else if (pend_valid_reg)
        begin
            step            = 1'b1;
            r_valid         = 1'b1;
            r.data          = pend_byte_reg;
            pend_valid_next = 1'b0;
        end
        else if (rp_len_reg != 3'd0)
        begin
            step      = 1'b1;
            byte_step = 1'b1;
            from_rp   = 1'b1;
            b         = rp_reg[0];
            b_cls     = qfp_pkg::classify(rp_reg[0]);
            for (int i = 0; i < RD - 1; i++)
            begin
                rp_next[i] = rp_reg[i+1];
            end
            rp_len_next = rp_len_reg - 3'd1;
        end
        else if (le_pend_reg)
        begin
            step    = 1'b1;
            r_valid = 1'b1;
            if (mode_reg == MODE_ENTITY)
            begin
                // unfinished entity at line end: '&' then reparse the rest
                r.data    = qfp_pkg::CH_AMP;
                mode_next = MODE_FIELD;
                cnt_next  = 3'd0;
                for (int i = 0; i < HD; i++)
                begin
                    rp_next[i] = hold_reg[i];
                end
                rp_len_next = cnt_reg - 3'd1;
            end
            else if (mode_reg == MODE_FIELD || mode_reg == MODE_QSEEN)
            begin
                r.kind    = qfp_pkg::KIND_EOF;
                bump      = 1'b1;
                mode_next = MODE_OUTSIDE;
            end
            else
            begin
                r.kind       = qfp_pkg::KIND_EOL;
                mode_next    = MODE_OUTSIDE;
                cnt_next     = 3'd0;
                field_next   = '0;
                le_pend_next = 1'b0;
            end
        end
        else if (head_valid)
        begin
            step         = 1'b1;
            byte_step    = 1'b1;
            pop_want     = 1'b1;
            le_pend_next = head.last;
        end

        if (byte_step)
        begin
            unique case (mode_reg)
                MODE_OUTSIDE:
                begin
                    if (b_cls == qfp_pkg::CLS_QUOTE)
                    begin
                        mode_next = MODE_QSEEN;
                    end
                end
                MODE_QSEEN:
                begin
                    if (b_cls == qfp_pkg::CLS_COMMA)
                    begin
                        mode_next = MODE_OUTSIDE;
                    end
                    else if (b_cls == qfp_pkg::CLS_QUOTE)
                    begin
                        r_valid   = 1'b1;
                        r.kind    = qfp_pkg::KIND_NULL;
                        bump      = 1'b1;
                        mode_next = MODE_SKIP;
                    end
                    else
                    begin
                        field_path = 1'b1;
                    end
                end
                MODE_SKIP:
                begin
                    mode_next = MODE_OUTSIDE;
                end
                MODE_FIELD:
                begin
                    field_path = 1'b1;
                end
                MODE_ENTITY:
                begin
                    ent_ok = (cnt_reg == 3'd1) ? (b == qfp_pkg::CH_HASH) :
                             (cnt_reg == 3'd2) ? (b == qfp_pkg::CH_LOWER_X) :
                             (cnt_reg == 3'd5) ? (b == qfp_pkg::CH_SEMI) : 1'b1;
                    if (ent_ok && cnt_reg != 3'd5)
                    begin
                        hold_we  = 1'b1;
                        cnt_next = cnt_reg + 3'd1;
                    end
                    else if (ent_ok)
                    begin
                        r_valid   = 1'b1;
                        mode_next = MODE_FIELD;
                        cnt_next  = 3'd0;
                        if (!hex_hi[4] || !hex_lo[4])
                        begin
                            r.data = qfp_pkg::CH_QMARK;
                        end
                        else if (hold_reg[2] <= qfp_pkg::CH_DIGIT9)
                        begin
                            r.data = dec_val;
                        end
                        else if (hold_reg[2] < qfp_pkg::CH_UPPER_C)
                        begin
                            r.data          = qfp_pkg::CH_LEAD_C2;
                            pend_valid_next = 1'b1;
                            pend_byte_next  = dec_val;
                        end
                        else
                        begin
                            r.data          = qfp_pkg::CH_LEAD_C3;
                            pend_valid_next = 1'b1;
                            pend_byte_next  = dec_val - qfp_pkg::LATIN_OFS;
                        end
                    end
                    else
                    begin
                        // broken entity: '&' out, held bytes and this one parsed again
                        r_valid   = 1'b1;
                        r.data    = qfp_pkg::CH_AMP;
                        mode_next = MODE_FIELD;
                        cnt_next  = 3'd0;
                        rest_len  = from_rp ? (rp_len_reg - 3'd1) : 3'd0;
                        for (int i = 0; i < RD; i++)
                        begin
                            rp_src = 3'(i) - k;
                            if (3'(i) < k)
                            begin
                                rp_next[i] = hold_reg[2'(i)];
                            end
                            else if (3'(i) == k)
                            begin
                                rp_next[i] = b;
                            end
                            else
                            begin
                                rp_next[i] = rp_reg[rp_src];
                            end
                        end
                        rp_len_next = k + 3'd1 + rest_len;
                    end
                end
                default:
                begin
                    mode_next = MODE_OUTSIDE;
                end
            endcase

            if (field_path)
            begin
                if (b_cls == qfp_pkg::CLS_QUOTE)
                begin
                    r_valid   = 1'b1;
                    r.kind    = qfp_pkg::KIND_EOF;
                    bump      = 1'b1;
                    mode_next = MODE_OUTSIDE;
                end
                else if (b_cls == qfp_pkg::CLS_AMP)
                begin
                    cnt_next  = 3'd1;
                    mode_next = MODE_ENTITY;
                end
                else
                begin
                    r_valid   = 1'b1;
                    r.data    = b;
                    mode_next = MODE_FIELD;
                end
            end
        end

        if (bump && field_reg < FIELD_LIMIT)
        begin
            field_next = field_reg + FW'(1);
        end
    end

    // one result is held back so the final one of an input can carry last
    always_comb
    begin
        done             = !pend_valid_next && (rp_len_next == 3'd0) && !le_pend_next;
        push             = 1'b0;
        push_last        = 1'b0;
        push_res         = stage_reg;
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        fin_pend_next    = fin_pend_reg;
        if (fin_step)
        begin
            push             = 1'b1;
            push_last        = 1'b1;
            stage_valid_next = 1'b0;
            fin_pend_next    = 1'b0;
        end
        else if (step)
        begin
            if (r_valid && stage_valid_reg)
            begin
                push          = 1'b1;
                stage_next    = r;
                fin_pend_next = done;
            end
            else if (r_valid)
            begin
                if (done)
                begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    push_res  = r;
                end
                else
                begin
                    stage_next       = r;
                    stage_valid_next = 1'b1;
                end
            end
            else if (stage_valid_reg && done)
            begin
                push             = 1'b1;
                push_last        = 1'b1;
                stage_valid_next = 1'b0;
            end
        end
        can_push = !out_valid_reg || res_ready;
        go       = !push || can_push;
    end

    assign pop       = pop_want && go;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign res_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_OUTSIDE;
            cnt_reg         <= 3'd0;
            field_reg       <= '0;
            rp_len_reg      <= 3'd0;
            pend_valid_reg  <= 1'b0;
            le_pend_reg     <= 1'b0;
            fin_pend_reg    <= 1'b0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                mode_reg        <= mode_next;
                cnt_reg         <= cnt_next;
                field_reg       <= field_next;
                rp_len_reg      <= rp_len_next;
                pend_valid_reg  <= pend_valid_next;
                le_pend_reg     <= le_pend_next;
                fin_pend_reg    <= fin_pend_next;
                stage_valid_reg <= stage_valid_next;
            end
            if (push && go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            pend_byte_reg <= pend_byte_next;
            stage_reg     <= stage_next;
            for (int i = 0; i < RD; i++)
            begin
                rp_reg[i] <= rp_next[i];
            end
            if (hold_we)
            begin
                hold_reg[hold_idx] <= b;
            end
        end
        if (push && go)
        begin
            out_reg      <= push_res;
            out_last_reg <= push_last;
        end
    end

endmodule

// File: rtl/core/quoted_field_parser_entity_decode.sv
// path: a plain field byte goes through the input queue and then the output register to m_tdata
// stepping: one result a cycle while the output register can take it; a byte with n
//   results takes n steps (at least one), one more when the held-back final result
//   collides, a broken entity adds a step per replayed byte, and line end adds a step
//   per flush action (open entity, field close, end of line)
// reset: asynchronous, clears the input queue, parser mode, field counter, output valid
module quoted_field_parser_entity_decode #(
    parameter int MAX_FIELDS = qfp_pkg::QFP_MAX_FIELDS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [13:8] field_number, [15:14] zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast     // last_of_run
);

    localparam logic [qfp_pkg::QFP_FIELD_W-1:0] FIELD_LIMIT =
        qfp_pkg::field_limit(MAX_FIELDS);

    logic                 head_valid;
    qfp_pkg::qfp_item_t   head;
    logic                 pop;
    qfp_pkg::qfp_result_t res;

    // front: input transfers land in a short queue, tagged with a byte class
    qfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // back: quote/field state machine, entity decode with replay, line end flush,
    // and the output register that decouples it from m_tready
    qfp_back #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res),
        .res_last   (m_tlast)
    );

    // pack the result onto the stream
    assign m_tdata = {2'b00, res.field, res.data};
    assign m_tuser = res.kind;

    // end of line always closes the results of its input byte
    a_eol_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == qfp_pkg::KIND_EOL) |-> m_tlast)
        else $error("end of line result without last");

    // only field bytes carry data
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != qfp_pkg::KIND_BYTE) |-> (m_tdata[7:0] == 8'h00))
        else $error("marker result with nonzero byte");

    // field counter saturates
    a_field_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:8] <= FIELD_LIMIT))
        else $error("field number above limit");

endmodule

// File: tb/quoted_field_parser_entity_decode_checker.sv
module quoted_field_parser_entity_decode_checker #(
    parameter int MAX_FIELDS = qfp_pkg::QFP_MAX_FIELDS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // line_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [7:0] out_byte, [13:8] field_number, [15:14] zero
    input  logic [1:0]  m_tuser,    // [1:0] kind
    input  logic        m_tlast,    // last_of_run
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);
    import qfp_pkg::*;

    localparam int FIELD_TOP  = (MAX_FIELDS - 1 < 63) ? MAX_FIELDS - 1 : 63;
    localparam int MAX_EVENTS = 9;
    localparam int REPORT_CAP = 100;

    typedef enum logic [2:0] {
        ST_OUTSIDE,
        ST_QSEEN,
        ST_SKIP,
        ST_FIELD,
        ST_ENTITY
    } parse_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [5:0] fnum;
        logic       last;
    } field_event_t;

    parse_state_t parse_state;
    logic [7:0]   held [5];
    int           held_cnt;
    int           field_idx;
    logic [7:0]   replay [8];
    field_event_t step_events [$];
    field_event_t expected_events [$];

    function automatic void clear_line();
        parse_state = ST_OUTSIDE;
        for (int i = 0; i < 5; i++)
        begin
            held[i] = 8'h00;
        end
        held_cnt  = 0;
        field_idx = 0;
    endfunction

    function automatic void push_event(input kind_t k, input logic [7:0] b);
        field_event_t ev;
        if (step_events.size() >= MAX_EVENTS)
        begin
            return;
        end
        ev.kind = k;
        ev.data = (k == KIND_BYTE) ? b : 8'h00;
        ev.fnum = 6'(field_idx);
        ev.last = 1'b0;
        step_events.push_back(ev);
    endfunction

    function automatic void bump_field();
        if (field_idx < FIELD_TOP)
        begin
            field_idx++;
        end
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9)
        begin
            return int'(c - CH_DIGIT0);
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            return int'(c - CH_UPPER_A) + 10;
        end
        return -1;
    endfunction

    // two digits sit in held[3], held[4]
    function automatic void decode_entity();
        int         hi;
        int         lo;
        logic [7:0] v;
        hi = hex_value(held[3]);
        lo = hex_value(held[4]);
        if (hi < 0 || lo < 0)
        begin
            push_event(KIND_BYTE, CH_QMARK);
        end
        else
        begin
            v = 8'((hi << 4) | lo);
            if (held[3] <= CH_DIGIT9)
            begin
                push_event(KIND_BYTE, v);
            end
            else if (held[3] < CH_UPPER_C)
            begin
                push_event(KIND_BYTE, CH_LEAD_C2);
                push_event(KIND_BYTE, v);
            end
            else
            begin
                push_event(KIND_BYTE, CH_LEAD_C3);
                push_event(KIND_BYTE, v - LATIN_OFS);
            end
        end
    endfunction

    function automatic void field_char(input logic [7:0] b);
        if (b == CH_QUOTE)
        begin
            push_event(KIND_EOF, 8'h00);
            bump_field();
            parse_state = ST_OUTSIDE;
        end
        else if (b == CH_AMP)
        begin
            held[0]     = b;
            held_cnt    = 1;
            parse_state = ST_ENTITY;
        end
        else
        begin
            push_event(KIND_BYTE, b);
        end
    endfunction

    // walks replay[0 .. count-1]; a broken entity refills the buffer and restarts
    function automatic void parse_bytes(input int count);
        int         len;
        int         h;
        int         n;
        int         k;
        logic [7:0] b;
        logic [7:0] tmp [8];
        logic       ok;
        len = count;
        h   = 0;
        while (h < len && h < 8)
        begin
            b = replay[h];
            h++;
            case (parse_state)
                ST_OUTSIDE:
                begin
                    if (b == CH_QUOTE)
                    begin
                        parse_state = ST_QSEEN;
                    end
                end
                ST_QSEEN:
                begin
                    if (b == CH_COMMA)
                    begin
                        parse_state = ST_OUTSIDE;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        push_event(KIND_NULL, 8'h00);
                        bump_field();
                        parse_state = ST_SKIP;
                    end
                    else
                    begin
                        parse_state = ST_FIELD;
                        field_char(b);
                    end
                end
                ST_SKIP:
                begin
                    parse_state = ST_OUTSIDE;
                end
                ST_ENTITY:
                begin
                    n = held_cnt;
                    if (n == 0 || n > 5)
                    begin
                        n = 1;
                    end
                    ok = (n == 1) ? (b == CH_HASH) :
                         (n == 2) ? (b == CH_LOWER_X) :
                         (n == 5) ? (b == CH_SEMI) : 1'b1;
                    if (ok && n < 5)
                    begin
                        held[n]  = b;
                        held_cnt = n + 1;
                    end
                    else if (ok)
                    begin
                        decode_entity();
                        held_cnt    = 0;
                        parse_state = ST_FIELD;
                    end
                    else
                    begin
                        push_event(KIND_BYTE, CH_AMP);
                        k = 0;
                        for (int i = 1; i < n && k < 8; i++)
                        begin
                            tmp[k] = held[i];
                            k++;
                        end
                        if (k < 8)
                        begin
                            tmp[k] = b;
                            k++;
                        end
                        while (h < len && h < 8 && k < 8)
                        begin
                            tmp[k] = replay[h];
                            k++;
                            h++;
                        end
                        for (int i = 0; i < k; i++)
                        begin
                            replay[i] = tmp[i];
                        end
                        len         = k;
                        h           = 0;
                        held_cnt    = 0;
                        parse_state = ST_FIELD;
                    end
                end
                default:
                begin
                    parse_state = ST_FIELD;
                    field_char(b);
                end
            endcase
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic line_end);
        int n;
        int k;
        step_events.delete();
        replay[0] = b;
        parse_bytes(1);
        if (line_end)
        begin
            // flush open entities, each flush may open another one
            while (parse_state == ST_ENTITY)
            begin
                n = held_cnt;
                if (n == 0 || n > 5)
                begin
                    n = 1;
                end
                k = 0;
                for (int i = 1; i < n; i++)
                begin
                    replay[k] = held[i];
                    k++;
                end
                push_event(KIND_BYTE, CH_AMP);
                held_cnt    = 0;
                parse_state = ST_FIELD;
                parse_bytes(k);
            end
            if (parse_state == ST_FIELD || parse_state == ST_QSEEN)
            begin
                push_event(KIND_EOF, 8'h00);
                bump_field();
            end
            push_event(KIND_EOL, 8'h00);
            clear_line();
        end
        if (step_events.size() > 0)
        begin
            step_events[step_events.size() - 1].last = 1'b1;
        end
        foreach (step_events[i])
        begin
            expected_events.push_back(step_events[i]);
        end
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= REPORT_CAP)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    function automatic void check_result();
        field_event_t want;
        if (expected_events.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d data %0h",
                         $time, m_tuser, m_tdata);
            end
            return;
        end
        want = expected_events.pop_front();
        checked_count++;
        if (m_tuser !== want.kind)
        begin
            note_mismatch("kind", want.kind, m_tuser);
        end
        if (m_tdata[7:0] !== want.data)
        begin
            note_mismatch("out_byte", want.data, m_tdata[7:0]);
        end
        if (m_tdata[13:8] !== want.fnum)
        begin
            note_mismatch("field_number", want.fnum, m_tdata[13:8]);
        end
        if (m_tdata[15:14] !== 2'b00)
        begin
            note_mismatch("tdata padding", 0, m_tdata[15:14]);
        end
        if (m_tlast !== want.last)
        begin
            note_mismatch("last_of_run", want.last, m_tlast);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            expected_events.delete();
            pending_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            pending_count = expected_events.size();
        end
    end

endmodule

// File: tb/quoted_field_parser_entity_decode_test.sv
module quoted_field_parser_entity_decode_test;
    import qfp_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_ITEMS   = 500;   // random part stops after this many transfers
    localparam int CALM_ITEMS     = 80;    // final stretch without idling
    localparam int LONG_LINE_AT   = 250;   // when the counter saturation line goes out
    localparam int SQUEEZE_AT     = 150;   // transfers before the long receiver hold-off
    localparam int SQUEEZE_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_FIELDS    = 70;    // more fields than the counter can count

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // [7:0] in_byte
    logic        s_tlast  = 1'b0;     // line_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;             // [7:0] out_byte, [13:8] field_number, [15:14] zero
    logic [1:0]  m_tuser;             // [1:0] kind
    logic        m_tlast;             // last_of_run

    int fail_count;
    int pending_count;
    int checked_count;

    int         items_sent    = 0;
    int         lines_sent    = 0;
    int         cycle_count   = 0;
    int         send_gap_pct  = 0;
    int         sink_stall_pct = 0;
    int         stall_left    = 0;
    int         rate_tick     = 0;
    logic       calm          = 1'b0;
    logic       squeeze_done  = 1'b0;
    logic [7:0] line_buf [$];

    quoted_field_parser_entity_decode dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // watches both channels, runs its own parser and compares every result
    quoted_field_parser_entity_decode_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run stopped by cycle limit of %0d", CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off to back the block up,
    // no stalls once the final stretch starts
    always @(posedge clk)
    begin
        rate_tick++;
        if (rate_tick % 50 == 0)
        begin
            case ($urandom_range(0, 3))
                0: sink_stall_pct = 0;
                1: sink_stall_pct = 5;
                2: sink_stall_pct = 20;
                default: sink_stall_pct = 50;
            endcase
        end
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!squeeze_done && items_sent >= SQUEEZE_AT)
        begin
            squeeze_done = 1'b1;
            stall_left   = SQUEEZE_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < sink_stall_pct)
        begin
            stall_left = $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // one transfer on the input side, with an optional idle burst first
    task automatic send_byte(input logic [7:0] b, input logic end_line);
        int idle;
        if (!calm && $urandom_range(0, 99) < send_gap_pct)
        begin
            idle = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= end_line;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_text(input string txt, input logic end_line);
        for (int i = 0; i < txt.len(); i++)
        begin
            send_byte(txt[i], end_line && (i == txt.len() - 1));
        end
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
        begin
            send_byte(line_buf[i], i == line_buf.size() - 1);
        end
        lines_sent++;
    endtask

    // mostly upper-case hex, some lower-case, a few arbitrary bytes
    function automatic logic [7:0] pick_hex();
        string upper_hex;
        string lower_hex;
        int    r;
        upper_hex = "0123456789ABCDEF";
        lower_hex = "abcdef";
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            return upper_hex[$urandom_range(0, 15)];
        end
        if (r < 90)
        begin
            return lower_hex[$urandom_range(0, 5)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // any byte, biased toward the ones the parser reacts to
    function automatic logic [7:0] pick_noise();
        string specials;
        specials = "\"&#x;,A9";
        if ($urandom_range(0, 99) < 40)
        begin
            return 8'($urandom_range(0, 255));
        end
        return specials[$urandom_range(0, specials.len() - 1)];
    endfunction

    // printable text that neither closes a field nor starts an entity
    function automatic logic [7:0] pick_text();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CH_QUOTE || c == CH_AMP)
        begin
            c = 8'h61;
        end
        return c;
    endfunction

    // &#xHH; now and then cut short and followed by a noise byte that may break it
    function automatic void put_entity();
        logic [7:0] seq [6];
        int         cut;
        seq = '{CH_AMP, CH_HASH, CH_LOWER_X, pick_hex(), pick_hex(), CH_SEMI};
        cut = 6;
        if ($urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, 5);
        end
        for (int i = 0; i < cut; i++)
        begin
            line_buf.push_back(seq[i]);
        end
        if (cut < 6)
        begin
            line_buf.push_back(pick_noise());
        end
    endfunction

    function automatic void put_field();
        int n;
        int r;
        line_buf.push_back(CH_QUOTE);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
            begin
                line_buf.push_back(pick_text());
            end
            else if (r < 9)
            begin
                put_entity();
            end
            else
            begin
                line_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        // sometimes left open so the line end has to close it
        if ($urandom_range(0, 9) != 0)
        begin
            line_buf.push_back(CH_QUOTE);
        end
    endfunction

    function automatic void build_line();
        int r;
        int n;
        line_buf.delete();
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            // well-formed comma separated line
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                begin
                    line_buf.push_back(CH_COMMA);
                end
                case ($urandom_range(0, 9))
                    6:
                    begin
                        // null field and the byte it swallows
                        line_buf.push_back(CH_QUOTE);
                        line_buf.push_back(CH_QUOTE);
                        line_buf.push_back($urandom_range(0, 1) ? CH_COMMA : pick_noise());
                    end
                    7:
                    begin
                        line_buf.push_back(CH_QUOTE);
                        line_buf.push_back(CH_COMMA);
                    end
                    8:
                    begin
                        for (int j = $urandom_range(1, 4); j > 0; j--)
                        begin
                            line_buf.push_back(pick_text());
                        end
                    end
                    9:
                    begin
                        put_entity();
                    end
                    default:
                    begin
                        put_field();
                    end
                endcase
            end
        end
        else if (r < 85)
        begin
            for (int i = $urandom_range(1, 16); i > 0; i--)
            begin
                line_buf.push_back(pick_noise());
            end
        end
        else
        begin
            // broken mixture of fields, entities and noise
            for (int i = $urandom_range(1, 10); i > 0; i--)
            begin
                case ($urandom_range(0, 2))
                    0: put_field();
                    1: put_entity();
                    default: line_buf.push_back(pick_noise());
                endcase
            end
        end
        if (line_buf.size() == 0)
        begin
            line_buf.push_back(pick_noise());
        end
    endfunction

    // enough short fields to run the field counter into its ceiling
    function automatic void build_long_line();
        line_buf.delete();
        for (int i = 0; i < LONG_FIELDS; i++)
        begin
            line_buf.push_back(CH_QUOTE);
            if ($urandom_range(0, 1))
            begin
                line_buf.push_back(pick_text());
                line_buf.push_back(CH_QUOTE);
            end
            else
            begin
                line_buf.push_back(CH_QUOTE);
                line_buf.push_back(CH_COMMA);
            end
        end
    endfunction

    initial
    begin : stimulus
        int   random_start;
        logic long_done;
        long_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: quote-comma, null field with its skipped byte, a field with
        // entities for a digit lead, an A-B lead and a lower-case digit, a broken
        // entity, zero and all-ones bytes, line end inside an entity, then a line
        // whose only byte is a quote waiting for its next byte
        send_gap_pct = 20;
        send_text("\",\"\"X\"&#x41;&#xA9;", 1'b0);
        send_text("&#xe9;&#y", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("&#x", 1'b1);
        send_byte(CH_QUOTE, 1'b1);
        lines_sent = 2;

        // random lines, mostly well-formed with random content
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (!long_done && items_sent - random_start >= LONG_LINE_AT)
            begin
                build_long_line();
                long_done = 1'b1;
            end
            else
            begin
                build_line();
            end
            if (items_sent - random_start >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                calm = 1'b1;
            end
            case ($urandom_range(0, 3))
                0, 1: send_gap_pct = 0;
                2: send_gap_pct = 10;
                default: send_gap_pct = 30;
            endcase
            send_line();
        end
        s_tvalid <= 1'b0;

        // drain: every expected result in, then a few quiet cycles for strays
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input bytes in %0d lines, %0d results checked",
                 items_sent, lines_sent, checked_count);
        $display("mix: null fields, quote-comma, good and broken entities, line ends inside"
                 , " entities and fields, field counter saturation, long output stall");
        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
